>>> sv/hashed_key_value_cache_macros.svh
// assertion macros for the key-value cache
`ifndef HASHED_KEY_VALUE_CACHE_MACROS_SVH
`define HASHED_KEY_VALUE_CACHE_MACROS_SVH
`ifndef ASSERT_OFF
`define HKV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define HKV_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define HKV_ASSERT(label, clk, rst_n, prop)
`define HKV_ASSERT_NORST(label, clk, prop)
`endif
`endif

>>> sv/hkv_cache_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkv_cache_pkg
// Shared constants for the hashed key-value cache.
// ----------------------------------------------------------------------------
package hkv_cache_pkg;
    localparam int BUCKETS_DEF     = 256;
    localparam int SLOTS_DEF       = 6;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int KEY_W           = 32;
    localparam int CFG_W           = 9;
    localparam int CNT_W           = 9;
    localparam int CFG_RESET       = 256;
    localparam logic KIND_INSERT   = 1'b0;
    localparam logic KIND_LOOKUP   = 1'b1;
endpackage

>>> sv/hashed_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_key_value_cache
// Key-value cache with small ring buckets.
// ----------------------------------------------------------------------------
// channel | direction | words
// s_      | in        | kind, key, store_value
// m_      | out       | found, read_value, entry_count
// cfg     | in        | bucket_count
// one word: restoring steps for key mod count, then a step to latch the
// bucket, a read of its state, a read and compare per slot, a write for an
// insert, and a step to load the result.
// an insert that overflows the total scans bucket state and flushes the first filled bucket.
// after reset the block sweeps the bucket state before s_ready.
// result sits in an output register; s_ready is low until it is taken.
module hashed_key_value_cache #(
    parameter int BUCKETS          = hkv_cache_pkg::BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = hkv_cache_pkg::SLOTS_DEF,
    parameter int VALUE_WIDTH      = hkv_cache_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hkv_cache_pkg::CFG_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [hkv_cache_pkg::KEY_W-1:0] s_key,
    input  logic [31:0]                     s_store_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic [31:0]                     m_read_value,
    output logic [hkv_cache_pkg::CNT_W-1:0] m_entry_count
);
    import hkv_cache_pkg::*;
`include "hashed_key_value_cache_macros.svh"

    localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SW   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int FW   = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int DEP  = BUCKETS * SLOTS_PER_BUCKET;
    localparam int AW   = $clog2(DEP);
    localparam int LW   = $clog2(BUCKETS + 1);
    localparam int ENTW = KEY_W + VALUE_WIDTH;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DIV, ST_META, ST_RDREQ, ST_RDCHK,
        ST_WRITE, ST_SCAN, ST_OUT
    } state_t;

    state_t state_reg;
    logic [CFG_W-1:0] cfg_reg;
    logic [BW-1:0] sweep_reg;
    logic kind_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [KEY_W-1:0] quo_reg;
    logic [LW-1:0] rem_reg;
    logic [5:0] step_reg;
    logic [LW-1:0] limit_reg;
    logic [BW-1:0] bkt_reg;
    logic [SW-1:0] old_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] age_reg;
    logic [SW-1:0] slot_reg;
    logic [CNT_W-1:0] total_reg;
    logic found_reg;
    logic [31:0] rd_reg;
    logic [CNT_W-1:0] cnt_out_reg;
    logic mvalid_reg;

    // bucket state memory: oldest slot and fill, per bucket
    logic [SW+FW-1:0] meta_mem [BUCKETS];
    logic [SW+FW-1:0] meta_rd_reg;
    logic [ENTW-1:0] ent_mem [DEP];
    logic [ENTW-1:0] ent_rd_reg;

    // effective bucket count, zero acts as one, clamped to BUCKETS
    logic [LW-1:0] limit_now;
    always_comb begin
        if (cfg_reg == '0) limit_now = LW'(1);
        else if (32'(cfg_reg) > 32'(BUCKETS)) limit_now = LW'(BUCKETS);
        else limit_now = LW'(cfg_reg);
    end

    // restoring division step, remainder only
    logic [LW:0] trial;
    assign trial = {rem_reg, quo_reg[KEY_W-1]} - {1'b0, limit_reg};

    // ring slot just past the newest entry
    logic [SW-1:0] ring_sum;
    logic [SW:0] ring_wide;
    assign ring_wide = (SW+1)'(old_reg) + (SW+1)'(fill_reg);
    assign ring_sum = (ring_wide >= (SW+1)'(SLOTS_PER_BUCKET))
        ? SW'(ring_wide - (SW+1)'(SLOTS_PER_BUCKET)) : SW'(ring_wide);

    logic [AW-1:0] ent_addr;
    assign ent_addr = AW'(32'(bkt_reg) * SLOTS_PER_BUCKET + 32'(slot_reg));

    logic [SW-1:0] old_inc;
    assign old_inc = (32'(old_reg) + 1 >= SLOTS_PER_BUCKET) ? '0 : SW'(old_reg + 1'b1);

    logic [FW-1:0] meta_fill;
    assign meta_fill = meta_rd_reg[FW-1:0];

    assign s_ready   = (state_reg == ST_IDLE) && !mvalid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = mvalid_reg;
    assign m_found   = found_reg;
    assign m_read_value  = rd_reg;
    assign m_entry_count = cnt_out_reg;

    // memories
    logic meta_we;
    logic [BW-1:0] meta_waddr, meta_raddr;
    logic [SW+FW-1:0] meta_wdata;
    logic ent_we;
    always_comb begin
        meta_we = 1'b0;
        meta_waddr = bkt_reg;
        meta_wdata = '0;
        meta_raddr = bkt_reg;
        ent_we = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                meta_we = 1'b1;
                meta_waddr = sweep_reg;
            end
            ST_RDCHK: begin
                if (!(age_reg < fill_reg && ent_rd_reg[ENTW-1 -: KEY_W] == key_reg)
                    && !(age_reg + 1'b1 < fill_reg) && kind_reg == KIND_INSERT
                    && !(age_reg < fill_reg && ent_rd_reg[ENTW-1 -: KEY_W] == key_reg)) begin
                    meta_we = 1'b0;
                end
            end
            ST_WRITE: begin
                meta_we = 1'b1;
                ent_we = 1'b1;
                if (fill_reg >= FW'(SLOTS_PER_BUCKET)) meta_wdata = {old_inc, fill_reg};
                else meta_wdata = {old_reg, FW'(fill_reg + 1'b1)};
            end
            ST_SCAN: begin
                meta_raddr = sweep_reg;
                if (meta_fill != '0 && step_reg[0]) begin
                    meta_we = 1'b1;
                    meta_waddr = sweep_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
        meta_rd_reg <= meta_mem[meta_raddr];
        if (ent_we) ent_mem[ent_addr] <= {key_reg, val_reg};
        ent_rd_reg <= ent_mem[ent_addr];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            cfg_reg    <= CFG_W'(CFG_RESET);
            sweep_reg  <= '0;
            total_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) cfg_reg <= cfg_data;
            if (mvalid_reg && m_ready) mvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: begin
                    sweep_reg <= BW'(sweep_reg + 1'b1);
                    if (32'(sweep_reg) == BUCKETS - 1) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        kind_reg  <= s_kind;
                        key_reg   <= s_key;
                        val_reg   <= VALUE_WIDTH'(s_store_value);
                        quo_reg   <= s_key;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        limit_reg <= limit_now;
                        found_reg <= 1'b0;
                        rd_reg    <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    quo_reg <= quo_reg << 1;
                    if (!trial[LW]) rem_reg <= LW'(trial);
                    else rem_reg <= LW'({rem_reg, quo_reg[KEY_W-1]});
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'(KEY_W - 1)) state_reg <= ST_META;
                end
                ST_META: begin
                    // latch the bucket, its state read starts next cycle
                    bkt_reg   <= BW'(rem_reg);
                    step_reg  <= '0;
                    state_reg <= ST_RDREQ;
                end
                ST_RDREQ: begin
                    if (step_reg == '0) begin
                        step_reg <= 6'd1;
                    end else begin
                        old_reg  <= meta_rd_reg[SW+FW-1:FW];
                        fill_reg <= meta_fill;
                        age_reg  <= '0;
                        slot_reg <= meta_rd_reg[SW+FW-1:FW];
                        step_reg <= '0;
                        if (meta_fill == '0) begin
                            state_reg <= (kind_reg == KIND_INSERT) ? ST_WRITE : ST_OUT;
                        end else begin
                            state_reg <= ST_RDCHK;
                        end
                    end
                end
                ST_RDCHK: begin
                    // per slot: address, then registered data
                    if (step_reg == '0) begin
                        step_reg <= 6'd1;
                    end else begin
                        step_reg <= '0;
                        if (ent_rd_reg[ENTW-1 -: KEY_W] == key_reg) begin
                            found_reg <= 1'b1;
                            if (kind_reg == KIND_LOOKUP)
                                rd_reg <= 32'(ent_rd_reg[VALUE_WIDTH-1:0]);
                            state_reg <= ST_OUT;
                        end else if (FW'(age_reg + 1'b1) < fill_reg) begin
                            age_reg  <= FW'(age_reg + 1'b1);
                            slot_reg <= (32'(slot_reg) + 1 >= SLOTS_PER_BUCKET)
                                ? '0 : SW'(slot_reg + 1'b1);
                        end else if (kind_reg == KIND_INSERT) begin
                            age_reg   <= fill_reg;
                            slot_reg  <= (fill_reg >= FW'(SLOTS_PER_BUCKET))
                                ? old_reg : ring_sum;
                            state_reg <= ST_WRITE;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_WRITE: begin
                    if (fill_reg >= FW'(SLOTS_PER_BUCKET)) begin
                        if (total_reg > CNT_W'(limit_reg)) begin
                            sweep_reg <= '0; step_reg <= '0; state_reg <= ST_SCAN;
                        end else state_reg <= ST_OUT;
                    end else begin
                        total_reg <= total_reg + 1'b1;
                        if (total_reg + 1'b1 > CNT_W'(limit_reg)) begin
                            sweep_reg <= '0; step_reg <= '0; state_reg <= ST_SCAN;
                        end else state_reg <= ST_OUT;
                    end
                end
                ST_SCAN: begin
                    // step 0 issues read, step 1 checks and clears
                    if (!step_reg[0]) begin
                        step_reg <= 6'd1;
                    end else begin
                        step_reg <= '0;
                        if (meta_fill != '0) begin
                            total_reg <= total_reg - CNT_W'(meta_fill);
                            state_reg <= ST_OUT;
                        end else if ((LW)'(sweep_reg) + 1'b1 >= limit_reg) begin
                            state_reg <= ST_OUT;
                        end else begin
                            sweep_reg <= BW'(sweep_reg + 1'b1);
                        end
                    end
                end
                ST_OUT: begin
                    mvalid_reg  <= 1'b1;
                    cnt_out_reg <= total_reg;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `HKV_ASSERT(a_no_accept_busy, aclk, aresetn, (state_reg != ST_IDLE) |-> !s_ready)
    `HKV_ASSERT(a_total_bound, aclk, aresetn, (state_reg == ST_IDLE) |-> (total_reg <= CNT_W'(256)))
    `HKV_ASSERT(a_out_after, aclk, aresetn, (state_reg == ST_OUT) |=> m_valid)
endmodule
